// ----- rtl/core/sle_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_pkg
// shared types and codes for the sorted list engine
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int DEFAULT_CAPACITY = 64;

	localparam int FUNC_W   = 2;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 6;
	localparam int FILL_W   = 7;

	typedef enum logic [FUNC_W-1:0] {
		FN_INSERT = 2'd0,
		FN_DELETE = 2'd1,
		FN_SEARCH = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK        = 2'd0,
		STS_NOT_FOUND = 2'd1,
		STS_FULL      = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DEL,
		ST_INS,
		ST_OUT
	} state_t;

endpackage

// ----- rtl/core/sle_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sle_mem
// value store, one write port and one registered read port
// ----------------------------------------------------------------------------
module sle_mem #(
	parameter int DEPTH = sle_pkg::DEFAULT_CAPACITY,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                              clk,
	input  logic                              we,
	input  logic [AW-1:0]                     waddr,
	input  logic signed [sle_pkg::VALUE_W-1:0] wdata,
	input  logic [AW-1:0]                     raddr,
	output logic signed [sle_pkg::VALUE_W-1:0] rdata
);

	logic signed [sle_pkg::VALUE_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/core/sorted_list_engine_top.sv -----
`timescale 1ns / 1ps
// operation: the scan steps up from rank 0 to the first entry not below the value; a delete
//   hit then pulls later entries down and an insert pushes entries from the top up to it and
//   writes the value there; a full insert and an unused func go straight to the result
// words: one at a time; the next word is taken the cycle after the result is loaded
// reset: arst_n clears the state, the count and out_valid only; other registers and store contents are not cleared
// ----------------------------------------------------------------------------
// sorted_list_engine_top
// ascending list of signed values with insert, delete and search
// ----------------------------------------------------------------------------
module sorted_list_engine_top #(
	parameter int CAPACITY = sle_pkg::DEFAULT_CAPACITY
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [sle_pkg::FUNC_W-1:0]         func,
	input  logic signed [sle_pkg::VALUE_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [sle_pkg::STATUS_W-1:0]       status,
	output logic [sle_pkg::POS_W-1:0]          position,
	output logic [sle_pkg::FILL_W-1:0]         fill
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	sle_pkg::state_t state_q, state_d;
	logic [CW-1:0] idx_q, idx_d;
	logic [CW-1:0] k_q, k_d;
	logic [CW-1:0] count_q, count_d;
	logic [sle_pkg::FUNC_W-1:0] func_q, func_d;
	logic signed [sle_pkg::VALUE_W-1:0] value_q, value_d;
	sle_pkg::status_t res_status_q, res_status_d;
	logic [CW-1:0] res_pos_q, res_pos_d;

	logic out_valid_q;
	logic [sle_pkg::STATUS_W-1:0] status_q;
	logic [sle_pkg::POS_W-1:0] position_q;
	logic [sle_pkg::FILL_W-1:0] fill_q;
	logic out_load;
	logic out_free;

	logic mem_we;
	logic [AW-1:0] mem_waddr;
	logic signed [sle_pkg::VALUE_W-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic signed [sle_pkg::VALUE_W-1:0] mem_rdata;

	logic in_range;
	logic less;
	logic equal;
	logic found;

	sle_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign in_range = idx_q < count_q;
	assign less     = mem_rdata < value_q;
	assign equal    = mem_rdata == value_q;
	assign found    = in_range && equal;
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		state_d      = state_q;
		idx_d        = idx_q;
		k_d          = k_q;
		count_d      = count_q;
		func_d       = func_q;
		value_d      = value_q;
		res_status_d = res_status_q;
		res_pos_d    = res_pos_q;
		mem_we       = 1'b0;
		mem_waddr    = AW'(idx_q);
		mem_wdata    = mem_rdata;
		mem_raddr    = '0;
		out_load     = 1'b0;
		case (state_q)
			sle_pkg::ST_IDLE: begin
				if (in_valid) begin
					func_d    = func;
					value_d   = value;
					idx_d     = '0;
					res_pos_d = '0;
					case (func)
						sle_pkg::FN_INSERT: begin
							if (count_q == CW'(CAPACITY)) begin
								res_status_d = sle_pkg::STS_FULL;
								state_d      = sle_pkg::ST_OUT;
							end else begin
								state_d = sle_pkg::ST_SCAN;
							end
						end
						sle_pkg::FN_DELETE, sle_pkg::FN_SEARCH: begin
							state_d = sle_pkg::ST_SCAN;
						end
						default: begin
							res_status_d = sle_pkg::STS_NOT_FOUND;
							state_d      = sle_pkg::ST_OUT;
						end
					endcase
				end
			end
			sle_pkg::ST_SCAN: begin
				mem_raddr = AW'(idx_q + CW'(1));
				if (in_range && less) begin
					idx_d = idx_q + CW'(1);
				end else begin
					k_d = idx_q;
					case (func_q)
						sle_pkg::FN_SEARCH: begin
							res_status_d = found ? sle_pkg::STS_OK : sle_pkg::STS_NOT_FOUND;
							res_pos_d    = found ? idx_q : '0;
							state_d      = sle_pkg::ST_OUT;
						end
						sle_pkg::FN_DELETE: begin
							if (found) begin
								state_d = sle_pkg::ST_DEL;
							end else begin
								res_status_d = sle_pkg::STS_NOT_FOUND;
								state_d      = sle_pkg::ST_OUT;
							end
						end
						sle_pkg::FN_INSERT: begin
							mem_raddr = AW'(count_q - CW'(1));
							idx_d     = count_q;
							state_d   = sle_pkg::ST_INS;
						end
						default: begin
							res_status_d = sle_pkg::STS_NOT_FOUND;
							state_d      = sle_pkg::ST_OUT;
						end
					endcase
				end
			end
			sle_pkg::ST_DEL: begin
				// pull each later value down by one place
				if ((idx_q + CW'(1)) < count_q) begin
					mem_we    = 1'b1;
					mem_wdata = mem_rdata;
					mem_raddr = AW'(idx_q + CW'(2));
					idx_d     = idx_q + CW'(1);
				end else begin
					count_d      = count_q - CW'(1);
					res_status_d = sle_pkg::STS_OK;
					state_d      = sle_pkg::ST_OUT;
				end
			end
			sle_pkg::ST_INS: begin
				// push values from the top up by one place, then drop in the new one
				mem_we = 1'b1;
				if (idx_q > k_q) begin
					mem_wdata = mem_rdata;
					mem_raddr = AW'(idx_q - CW'(2));
					idx_d     = idx_q - CW'(1);
				end else begin
					mem_wdata    = value_q;
					count_d      = count_q + CW'(1);
					res_status_d = sle_pkg::STS_OK;
					state_d      = sle_pkg::ST_OUT;
				end
			end
			sle_pkg::ST_OUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = sle_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = sle_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sle_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_q        <= idx_d;
		k_q          <= k_d;
		func_q       <= func_d;
		value_q      <= value_d;
		res_status_q <= res_status_d;
		res_pos_q    <= res_pos_d;
		if (out_load) begin
			status_q   <= res_status_q;
			position_q <= sle_pkg::POS_W'(res_pos_q);
			fill_q     <= sle_pkg::FILL_W'(count_q);
		end
	end

	assign in_stall  = state_q != sle_pkg::ST_IDLE;
	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign position  = position_q;
	assign fill      = fill_q;

endmodule
